/* rtl/core/utcp_pkg.sv */
// Shared types and constants for the telemetry and command parser.
package utcp_pkg;

  localparam logic [7:0] CMD_PHASE_RESET  = 8'h77;
  localparam logic [7:0] CMD_FRAME_START  = 8'h99;
  localparam logic [7:0] CMD_FRAME_END    = 8'hCC;
  localparam logic [7:0] HDR_ANGLE        = 8'h80;
  localparam logic [7:0] HDR_CURRENT      = 8'h90;
  localparam logic [7:0] HDR_VOLTAGE      = 8'hA0;
  localparam logic [7:0] REPLY_PARAM_HI   = 8'h44;
  localparam logic [7:0] REPLY_PARAM_DONE = 8'h55;
  localparam logic [7:0] REPLY_ERROR      = 8'hFF;
  localparam logic [7:0] NIBBLE_MASK      = 8'h0F;

  localparam int unsigned NUM_PARAMS = 8;

  localparam logic [7:0] STORE_INIT [NUM_PARAMS] = '{
    8'd8, 8'd1, 8'd4, 8'd32, 8'd1, 8'd1, 8'd1, 8'd20
  };

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_ANG_HDR  = 4'd1,
    PH_ANG_N1   = 4'd2,
    PH_ANG_N2   = 4'd3,
    PH_ANG_N3   = 4'd4,
    PH_CUR_HDR  = 4'd5,
    PH_CUR_N1   = 4'd6,
    PH_CUR_N2   = 4'd7,
    PH_CUR_N3   = 4'd8,
    PH_CUR_SIGN = 4'd9,
    PH_VOL_HDR  = 4'd10,
    PH_VOL_N1   = 4'd11,
    PH_VOL_N2   = 4'd12,
    PH_VOL_N3   = 4'd13,
    PH_VOL_SIGN = 4'd14,
    PH_END      = 4'd15
  } frame_phase_e;

  typedef struct packed {
    logic [7:0] reply;
    logic       written;
    logic [2:0] idx;
    logic [7:0] val;
  } param_res_t;

  typedef struct packed {
    logic [7:0]  reply;
    logic        done;
    logic        param_clr;
    logic [15:0] angle;
    logic [15:0] current;
    logic        current_neg;
    logic [15:0] voltage;
    logic        voltage_neg;
  } frame_res_t;

endpackage

/* rtl/core/uart_telemetry_command_parser.sv */
// Top level of the telemetry and command parser: input stage, units, result register.
// Each input byte passes through the input stage register and then the result register.
// Throughput: one byte per cycle; the input stage advances whenever the result register
// is empty or drains in the same cycle.
// Reset: phases return to idle, pending slots and telemetry values clear,
// and the parameter store loads its default values {8,1,4,32,1,1,1,20}.
module uart_telemetry_command_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  reply_o,
  output logic        mode_bit_o,
  output logic        param_written_o,
  output logic [2:0]  param_index_o,
  output logic [7:0]  param_value_o,
  output logic        frame_complete_o,
  output logic [15:0] angle_o,
  output logic [15:0] current_o,
  output logic        current_sign_o,
  output logic [15:0] voltage_o,
  output logic        voltage_sign_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_adv, s1_fire, in_xfer;
  logic       out_valid_q, out_valid_d;
  logic       param_en, frame_en;

  utcp_pkg::param_res_t param_res;
  utcp_pkg::frame_res_t frame_res;

  logic [7:0]  reply_q;
  logic        mode_bit_q;
  logic        written_q;
  logic [2:0]  idx_q;
  logic [7:0]  val_q;
  logic        done_q;
  logic [15:0] angle_q;
  logic [15:0] current_q;
  logic        cur_sign_q;
  logic [15:0] voltage_q;
  logic        vol_sign_q;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign param_en   = s1_fire && !s1_byte_q[7];
  assign frame_en   = s1_fire && s1_byte_q[7];

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  utcp_param u_param (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (param_en),
    .clr_i     (frame_res.param_clr),
    .rx_byte_i (s1_byte_q),
    .res_o     (param_res)
  );

  utcp_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (frame_en),
    .rx_byte_i (s1_byte_q),
    .res_o     (frame_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= rx_byte_i;
    end
    if (s1_fire) begin
      mode_bit_q <= s1_byte_q[7];
      if (s1_byte_q[7]) begin
        reply_q   <= frame_res.reply;
        written_q <= 1'b0;
        idx_q     <= 3'd0;
        val_q     <= 8'h00;
        done_q    <= frame_res.done;
      end else begin
        reply_q   <= param_res.reply;
        written_q <= param_res.written;
        idx_q     <= param_res.idx;
        val_q     <= param_res.val;
        done_q    <= 1'b0;
      end
      angle_q    <= frame_res.angle;
      current_q  <= frame_res.current;
      cur_sign_q <= ~frame_res.current_neg;
      voltage_q  <= frame_res.voltage;
      vol_sign_q <= ~frame_res.voltage_neg;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign reply_o          = reply_q;
  assign mode_bit_o       = mode_bit_q;
  assign param_written_o  = written_q;
  assign param_index_o    = idx_q;
  assign param_value_o    = val_q;
  assign frame_complete_o = done_q;
  assign angle_o          = angle_q;
  assign current_o        = current_q;
  assign current_sign_o   = cur_sign_q;
  assign voltage_o        = voltage_q;
  assign voltage_sign_o   = vol_sign_q;

  a_stall_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i)
  ) else $error("input stalled while result path could advance");

  a_written_is_param: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && param_written_o) |->
      (reply_o == utcp_pkg::REPLY_PARAM_DONE && !mode_bit_o)
  ) else $error("parameter commit without commit reply");

  a_done_is_frame: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_complete_o) |->
      (reply_o == utcp_pkg::CMD_FRAME_END && mode_bit_o)
  ) else $error("frame end without terminator reply");

  a_frame_param_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode_bit_o) |-> (param_index_o == 3'd0 && param_value_o == 8'h00)
  ) else $error("parameter fields set on a telemetry byte");

endmodule

/* rtl/core/utcp_param.sv */
// Parameter command unit: two-phase nibble assembly into the parameter store.
module utcp_param (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  clr_i,
  input  logic [7:0]            rx_byte_i,
  output utcp_pkg::param_res_t  res_o
);

  logic       phase_q, phase_d;
  logic [7:0] pending_q [utcp_pkg::NUM_PARAMS];
  logic [7:0] pending_d [utcp_pkg::NUM_PARAMS];
  logic [7:0] store_q [utcp_pkg::NUM_PARAMS];
  logic [7:0] store_d [utcp_pkg::NUM_PARAMS];
  logic [2:0] idx;
  logic [3:0] lo;
  logic [7:0] merged;

  assign idx    = rx_byte_i[6:4];
  assign lo     = rx_byte_i[3:0] & utcp_pkg::NIBBLE_MASK[3:0];
  assign merged = pending_q[idx] | {4'b0000, lo};

  always_comb begin
    phase_d       = phase_q;
    pending_d     = pending_q;
    store_d       = store_q;
    res_o.reply   = utcp_pkg::CMD_PHASE_RESET;
    res_o.written = 1'b0;
    if (rx_byte_i == utcp_pkg::CMD_PHASE_RESET) begin
      if (en_i) begin
        phase_d = 1'b0;
      end
    end else if (!phase_q) begin
      res_o.reply = utcp_pkg::REPLY_PARAM_HI;
      if (en_i) begin
        pending_d[idx] = {lo, 4'b0000};
        phase_d        = 1'b1;
      end
    end else begin
      res_o.reply   = utcp_pkg::REPLY_PARAM_DONE;
      res_o.written = 1'b1;
      if (en_i) begin
        store_d[idx]   = merged;
        pending_d[idx] = 8'h00;
        phase_d        = 1'b0;
      end
    end
    if (clr_i) begin
      phase_d = 1'b0;
    end
    res_o.idx = idx;
    res_o.val = store_d[idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 1'b0;
      pending_q <= '{default: '0};
      store_q   <= utcp_pkg::STORE_INIT;
    end else begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
      store_q   <= store_d;
    end
  end

endmodule

/* rtl/core/utcp_frame.sv */
// Telemetry frame unit: 16-phase sequencer assembling angle, current and voltage, with current and voltage signs.
module utcp_frame (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [7:0]            rx_byte_i,
  output utcp_pkg::frame_res_t  res_o
);

  utcp_pkg::frame_phase_e phase_q, phase_d, phase_inc;
  logic [15:0] asm_q, asm_d;
  logic [15:0] angle_q, angle_d;
  logic [15:0] current_q, current_d;
  logic [15:0] voltage_q, voltage_d;
  logic        cur_neg_q, cur_neg_d;
  logic        vol_neg_q, vol_neg_d;
  logic [3:0]  lo;
  logic        sign_ok;

  assign lo        = rx_byte_i[3:0];
  assign sign_ok   = (lo[3:1] == 3'b000);
  assign phase_inc = utcp_pkg::frame_phase_e'(phase_q + 4'd1);

  always_comb begin
    phase_d         = phase_q;
    asm_d           = asm_q;
    angle_d         = angle_q;
    current_d       = current_q;
    voltage_d       = voltage_q;
    cur_neg_d       = cur_neg_q;
    vol_neg_d       = vol_neg_q;
    res_o.reply     = utcp_pkg::REPLY_ERROR;
    res_o.done      = 1'b0;
    res_o.param_clr = 1'b0;
    case (phase_q)
      utcp_pkg::PH_IDLE: begin
        res_o.param_clr = en_i;
        if (rx_byte_i == utcp_pkg::CMD_FRAME_START) begin
          res_o.reply = utcp_pkg::CMD_FRAME_START;
          phase_d     = utcp_pkg::PH_ANG_HDR;
        end
      end
      utcp_pkg::PH_ANG_HDR: begin
        if (rx_byte_i[7:4] == utcp_pkg::HDR_ANGLE[7:4]) begin
          res_o.reply = utcp_pkg::HDR_ANGLE;
          asm_d       = {lo, 12'h000};
          phase_d     = phase_inc;
        end
      end
      utcp_pkg::PH_CUR_HDR: begin
        if (rx_byte_i[7:4] == utcp_pkg::HDR_CURRENT[7:4]) begin
          res_o.reply = utcp_pkg::HDR_CURRENT;
          asm_d       = {lo, 12'h000};
          phase_d     = phase_inc;
        end
      end
      utcp_pkg::PH_VOL_HDR: begin
        if (rx_byte_i[7:4] == utcp_pkg::HDR_VOLTAGE[7:4]) begin
          res_o.reply = utcp_pkg::HDR_VOLTAGE;
          asm_d       = {lo, 12'h000};
          phase_d     = phase_inc;
        end
      end
      utcp_pkg::PH_ANG_N1: begin
        res_o.reply = utcp_pkg::HDR_ANGLE;
        asm_d       = asm_q | {4'h0, lo, 8'h00};
        phase_d     = phase_inc;
      end
      utcp_pkg::PH_ANG_N2: begin
        res_o.reply = utcp_pkg::HDR_ANGLE;
        asm_d       = asm_q | {8'h00, lo, 4'h0};
        phase_d     = phase_inc;
      end
      utcp_pkg::PH_ANG_N3: begin
        res_o.reply = utcp_pkg::HDR_ANGLE;
        angle_d     = asm_q | {12'h000, lo};
        asm_d       = 16'h0000;
        phase_d     = phase_inc;
      end
      utcp_pkg::PH_CUR_N1: begin
        res_o.reply = utcp_pkg::HDR_CURRENT;
        asm_d       = asm_q | {4'h0, lo, 8'h00};
        phase_d     = phase_inc;
      end
      utcp_pkg::PH_CUR_N2: begin
        res_o.reply = utcp_pkg::HDR_CURRENT;
        asm_d       = asm_q | {8'h00, lo, 4'h0};
        phase_d     = phase_inc;
      end
      utcp_pkg::PH_CUR_N3: begin
        res_o.reply = utcp_pkg::HDR_CURRENT;
        current_d   = asm_q | {12'h000, lo};
        asm_d       = 16'h0000;
        phase_d     = phase_inc;
      end
      utcp_pkg::PH_VOL_N1: begin
        res_o.reply = utcp_pkg::HDR_VOLTAGE;
        asm_d       = asm_q | {4'h0, lo, 8'h00};
        phase_d     = phase_inc;
      end
      utcp_pkg::PH_VOL_N2: begin
        res_o.reply = utcp_pkg::HDR_VOLTAGE;
        asm_d       = asm_q | {8'h00, lo, 4'h0};
        phase_d     = phase_inc;
      end
      utcp_pkg::PH_VOL_N3: begin
        res_o.reply = utcp_pkg::HDR_VOLTAGE;
        voltage_d   = asm_q | {12'h000, lo};
        asm_d       = 16'h0000;
        phase_d     = phase_inc;
      end
      utcp_pkg::PH_CUR_SIGN: begin
        if (sign_ok) begin
          res_o.reply = utcp_pkg::HDR_CURRENT;
          cur_neg_d   = ~lo[0];
          phase_d     = phase_inc;
        end
      end
      utcp_pkg::PH_VOL_SIGN: begin
        if (sign_ok) begin
          res_o.reply = utcp_pkg::HDR_VOLTAGE;
          vol_neg_d   = ~lo[0];
          phase_d     = phase_inc;
        end
      end
      utcp_pkg::PH_END: begin
        if (rx_byte_i == utcp_pkg::CMD_FRAME_END) begin
          res_o.reply = utcp_pkg::CMD_FRAME_END;
          res_o.done  = 1'b1;
          phase_d     = utcp_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_d = utcp_pkg::PH_IDLE;
      end
    endcase
    res_o.angle       = en_i ? angle_d : angle_q;
    res_o.current     = en_i ? current_d : current_q;
    res_o.voltage     = en_i ? voltage_d : voltage_q;
    res_o.current_neg = en_i ? cur_neg_d : cur_neg_q;
    res_o.voltage_neg = en_i ? vol_neg_d : vol_neg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= utcp_pkg::PH_IDLE;
      asm_q     <= 16'h0000;
      angle_q   <= 16'h0000;
      current_q <= 16'h0000;
      voltage_q <= 16'h0000;
      cur_neg_q <= 1'b0;
      vol_neg_q <= 1'b0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      asm_q     <= asm_d;
      angle_q   <= angle_d;
      current_q <= current_d;
      voltage_q <= voltage_d;
      cur_neg_q <= cur_neg_d;
      vol_neg_q <= vol_neg_d;
    end
  end

endmodule

/* tb/uart_telemetry_command_parser_tb.sv */
// Self-checking testbench for the telemetry and command parser: byte stream in, replies checked.
module uart_telemetry_command_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utcp_pkg::*;

  localparam int RANDOM_BYTES = 600;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_DIRECTED = 27;

  localparam logic [7:0] DIRECTED_BYTES [NUM_DIRECTED] = '{
    8'h3A, 8'h85, 8'h3B, 8'h77, 8'h05, 8'h6F, 8'h00, 8'h99, 8'h7F,
    8'h90, 8'h8F, 8'h99, 8'hFF, 8'h80, 8'h9F, 8'hF0, 8'h8F, 8'hB7,
    8'h82, 8'h80, 8'h70, 8'hA0, 8'hFF, 8'hFF, 8'h81, 8'hCB, 8'hCC
  };

  typedef struct packed {
    logic [7:0]  reply;
    logic        mode;
    logic        written;
    logic [2:0]  idx;
    logic [7:0]  val;
    logic        done;
    logic [15:0] angle;
    logic [15:0] current;
    logic        current_sign;
    logic [15:0] voltage;
    logic        voltage_sign;
  } reply_rec_t;

  class reply_predictor;
    bit           cmd_second;
    frame_phase_e phase;
    logic [7:0]   slot [NUM_PARAMS];
    logic [7:0]   store [NUM_PARAMS];
    logic [15:0]  word;
    logic [15:0]  ang;
    logic [15:0]  cur;
    logic [15:0]  vol;
    bit           cur_neg;
    bit           vol_neg;
    reply_rec_t   expected_replies [$];
    int           mismatches;

    function new();
      cmd_second = 1'b0;
      phase = PH_IDLE;
      word = '0;
      ang = '0;
      cur = '0;
      vol = '0;
      cur_neg = 1'b0;
      vol_neg = 1'b0;
      mismatches = 0;
      foreach (slot[i]) begin
        slot[i] = '0;
        store[i] = STORE_INIT[i];
      end
    endfunction

    function logic [7:0] frame_byte(logic [7:0] b, output bit done);
      logic [3:0] lo;
      logic [7:0] hdr;
      int pos;
      lo = b[3:0];
      done = 1'b0;
      hdr = HDR_ANGLE;
      pos = 0;
      case (phase)
        PH_IDLE: begin
          cmd_second = 1'b0;
          if (b != CMD_FRAME_START) return REPLY_ERROR;
          phase = PH_ANG_HDR;
          return CMD_FRAME_START;
        end
        PH_ANG_HDR, PH_CUR_HDR, PH_VOL_HDR: begin
          hdr = (phase == PH_ANG_HDR) ? HDR_ANGLE :
                (phase == PH_CUR_HDR) ? HDR_CURRENT : HDR_VOLTAGE;
          if (b[7:4] != hdr[7:4]) return REPLY_ERROR;
          word = {lo, 12'h000};
          phase = frame_phase_e'(phase + 1);
          return hdr;
        end
        PH_CUR_SIGN, PH_VOL_SIGN: begin
          if (lo > 4'd1) return REPLY_ERROR;
          if (phase == PH_CUR_SIGN) begin
            cur_neg = (lo == 4'd0);
            hdr = HDR_CURRENT;
          end else begin
            vol_neg = (lo == 4'd0);
            hdr = HDR_VOLTAGE;
          end
          phase = frame_phase_e'(phase + 1);
          return hdr;
        end
        PH_END: begin
          if (b != CMD_FRAME_END) return REPLY_ERROR;
          phase = PH_IDLE;
          done = 1'b1;
          return CMD_FRAME_END;
        end
        default: begin
          if (phase <= PH_ANG_N3) begin
            pos = phase - PH_ANG_N1;
            hdr = HDR_ANGLE;
          end else if (phase <= PH_CUR_N3) begin
            pos = phase - PH_CUR_N1;
            hdr = HDR_CURRENT;
          end else begin
            pos = phase - PH_VOL_N1;
            hdr = HDR_VOLTAGE;
          end
          word = word | (16'(lo) << (8 - 4 * pos));
          if (pos == 2) begin
            if (hdr == HDR_ANGLE) ang = word;
            else if (hdr == HDR_CURRENT) cur = word;
            else vol = word;
            word = '0;
          end
          phase = frame_phase_e'(phase + 1);
          return hdr;
        end
      endcase
    endfunction

    function void note_rx_byte(logic [7:0] b);
      reply_rec_t r;
      bit done;
      logic [2:0] idx;
      r = '0;
      done = 1'b0;
      r.mode = b[7];
      if (b[7]) begin
        r.reply = frame_byte(b, done);
        r.done = done;
      end else begin
        idx = b[6:4];
        if (b == CMD_PHASE_RESET) begin
          cmd_second = 1'b0;
          r.reply = CMD_PHASE_RESET;
        end else if (!cmd_second) begin
          slot[idx] = {b[3:0], 4'h0};
          cmd_second = 1'b1;
          r.reply = REPLY_PARAM_HI;
        end else begin
          store[idx] = slot[idx] | {4'h0, b[3:0]};
          slot[idx] = '0;
          cmd_second = 1'b0;
          r.written = 1'b1;
          r.reply = REPLY_PARAM_DONE;
        end
        r.idx = idx;
        r.val = store[idx];
      end
      r.angle = ang;
      r.current = cur;
      r.current_sign = !cur_neg;
      r.voltage = vol;
      r.voltage_sign = !vol_neg;
      expected_replies.push_back(r);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_reply(reply_rec_t got);
      reply_rec_t e;
      if (expected_replies.size() == 0) begin
        $error("reply %0h with no byte outstanding", got.reply);
        mismatches++;
        return;
      end
      e = expected_replies.pop_front();
      compare("reply", 16'(e.reply), 16'(got.reply));
      compare("mode_bit", 16'(e.mode), 16'(got.mode));
      compare("param_written", 16'(e.written), 16'(got.written));
      compare("param_index", 16'(e.idx), 16'(got.idx));
      compare("param_value", 16'(e.val), 16'(got.val));
      compare("frame_complete", 16'(e.done), 16'(got.done));
      compare("angle", e.angle, got.angle);
      compare("current", e.current, got.current);
      compare("current_sign", 16'(e.current_sign), 16'(got.current_sign));
      compare("voltage", e.voltage, got.voltage);
      compare("voltage_sign", 16'(e.voltage_sign), 16'(got.voltage_sign));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  reply_o;
  logic        mode_bit_o;
  logic        param_written_o;
  logic [2:0]  param_index_o;
  logic [7:0]  param_value_o;
  logic        frame_complete_o;
  logic [15:0] angle_o;
  logic [15:0] current_o;
  logic        current_sign_o;
  logic [15:0] voltage_o;
  logic        voltage_sign_o;

  reply_predictor predictor;
  logic [7:0]     rx_bytes [$];

  uart_telemetry_command_parser i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .reply_o          (reply_o),
    .mode_bit_o       (mode_bit_o),
    .param_written_o  (param_written_o),
    .param_index_o    (param_index_o),
    .param_value_o    (param_value_o),
    .frame_complete_o (frame_complete_o),
    .angle_o          (angle_o),
    .current_o        (current_o),
    .current_sign_o   (current_sign_o),
    .voltage_o        (voltage_o),
    .voltage_sign_o   (voltage_sign_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // occasionally slip a stray byte into a frame
  task automatic push_frame_byte(logic [7:0] b);
    if ($urandom_range(0, 39) == 0) rx_bytes.push_back(8'($urandom_range(0, 255)));
    rx_bytes.push_back(b);
  endtask

  task automatic add_frame();
    logic [7:0] hdr [3];
    hdr = '{HDR_ANGLE, HDR_CURRENT, HDR_VOLTAGE};
    push_frame_byte(CMD_FRAME_START);
    for (int g = 0; g < 3; g++) begin
      push_frame_byte({hdr[g][7:4], 4'($urandom)});
      repeat (3) push_frame_byte({1'b1, 7'($urandom)});
      if (g > 0) push_frame_byte({1'b1, 3'($urandom), 3'b000, 1'($urandom)});
    end
    push_frame_byte(CMD_FRAME_END);
  endtask

  task automatic add_param_pair();
    logic [2:0] idx;
    idx = 3'($urandom);
    rx_bytes.push_back({1'b0, idx, 4'($urandom)});
    if ($urandom_range(0, 9) == 0) rx_bytes.push_back(CMD_PHASE_RESET);
    if ($urandom_range(0, 3) == 0) idx = 3'($urandom);
    rx_bytes.push_back({1'b0, idx, 4'($urandom)});
  endtask

  initial begin : stimulus
    int gap;
    int pick;
    bit tx_quiet;
    tx_quiet = 1'b0;
    predictor = new();
    foreach (DIRECTED_BYTES[i]) rx_bytes.push_back(DIRECTED_BYTES[i]);
    while (rx_bytes.size() < NUM_DIRECTED + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) add_frame();
      else if (pick < 85) add_param_pair();
      else repeat ($urandom_range(1, 3)) rx_bytes.push_back(8'($urandom_range(0, 255)));
    end

    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    rx_byte_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rx_bytes[i]) begin
      if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
      gap = pick_gap(tx_quiet);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      rx_byte_i <= rx_bytes[i];
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      predictor.note_rx_byte(rx_bytes[i]);
    end
    in_valid_i <= 1'b0;

    while (predictor.expected_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (predictor.mismatches == 0 && predictor.expected_replies.size() == 0) begin
      $display("PASS uart_telemetry_command_parser");
    end else begin
      $display("FAIL uart_telemetry_command_parser");
    end
    $finish;
  end

  initial begin : reply_monitor
    reply_rec_t seen;
    int hold_left;
    bit rx_quiet;
    hold_left = 0;
    rx_quiet = 1'b0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        seen = {reply_o, mode_bit_o, param_written_o, param_index_o, param_value_o,
                frame_complete_o, angle_o, current_o, current_sign_o, voltage_o,
                voltage_sign_o};
        predictor.check_reply(seen);
      end
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      if (hold_left == 0 && $urandom_range(0, 2) == 0) hold_left = pick_gap(rx_quiet);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL uart_telemetry_command_parser");
    $finish;
  end

endmodule
